### rtl/core/fmqd_pkg.sv
// ----------------------------------------------------------------------------
// fmqd_pkg
// Shared constants, types and the arctangent table of the FM discriminator.
// ----------------------------------------------------------------------------
package fmqd_pkg;

  localparam int PHASE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int RAW_W  = 8;
  localparam int CEN_W  = 9;
  localparam int PROD_W = 2 * CEN_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int XW     = 30;
  localparam int ZW     = PHASE_BITS + 2;
  localparam int OUT_W  = 16;
  localparam int SHW    = $clog2(CORDIC_STAGES);

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  localparam logic [OUT_W-1:0] PH_ZERO    = 16'h0000;
  localparam logic [OUT_W-1:0] PH_PI      = 16'h8000;
  localparam logic [OUT_W-1:0] PH_HALF_PI = 16'h4000;
  localparam logic [OUT_W-1:0] PH_NEG_HPI = 16'hC000;

  typedef struct packed {
    logic                    vld;
    logic                    byp;
    logic [OUT_W-1:0]        byp_val;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
  } cord_t;

  // stage angle rounded half up to units of pi/2^(PHASE_BITS-1)
  function automatic logic signed [ZW-1:0] stage_angle(input int k);
    logic [32:0] t;
    t = {1'b0, ATAN_TAB[k]} + (33'd1 << (31 - PHASE_BITS));
    return ZW'(t >> (32 - PHASE_BITS));
  endfunction

endpackage

### rtl/core/fmqd_front.sv
// ----------------------------------------------------------------------------
// fmqd_front
// Centres the sample, forms the conjugate product with the previous sample,
// detects the axis cases and applies the quadrant pre-rotation.
// ----------------------------------------------------------------------------
module fmqd_front import fmqd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             acc,
  input  logic [RAW_W-1:0] i_raw,
  input  logic [RAW_W-1:0] q_raw,
  input  logic             restart,
  output cord_t            q
);

  logic signed [CEN_W-1:0]  last_i_r, last_q_r;
  logic                     have_r;
  logic signed [CEN_W-1:0]  ci, cq;
  logic signed [CEN_W:0]    ci_w, cq_w;

  logic                     pv_r;
  logic signed [PROD_W-1:0] p_ii_r, p_qq_r, p_qi_r, p_iq_r;

  logic signed [SUM_W-1:0]  re, im;
  logic signed [XW-1:0]     xe, ye;
  cord_t                    q_r, q_nxt;

  assign ci_w = $signed({1'b0, i_raw, 1'b0}) - 10'sd255;
  assign cq_w = $signed({1'b0, q_raw, 1'b0}) - 10'sd255;
  assign ci   = ci_w[CEN_W-1:0];
  assign cq   = cq_w[CEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_i_r <= '0;
      last_q_r <= '0;
      have_r   <= 1'b0;
      pv_r     <= 1'b0;
    end else if (en) begin
      pv_r <= acc && have_r && !restart;
      if (acc) begin
        last_i_r <= ci;
        last_q_r <= cq;
        have_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && acc) begin
      p_ii_r <= ci * last_i_r;
      p_qq_r <= cq * last_q_r;
      p_qi_r <= cq * last_i_r;
      p_iq_r <= ci * last_q_r;
    end
  end

  assign re = {p_ii_r[PROD_W-1], p_ii_r} + {p_qq_r[PROD_W-1], p_qq_r};
  assign im = {p_qi_r[PROD_W-1], p_qi_r} - {p_iq_r[PROD_W-1], p_iq_r};
  assign xe = {{(XW-SUM_W){re[SUM_W-1]}}, re} <<< 8;
  assign ye = {{(XW-SUM_W){im[SUM_W-1]}}, im} <<< 8;

  always_comb begin
    q_nxt         = '0;
    q_nxt.vld     = pv_r;
    q_nxt.x       = xe;
    q_nxt.y       = ye;
    q_nxt.z       = '0;
    if (re == '0 && im == '0) begin
      q_nxt.byp     = 1'b1;
      q_nxt.byp_val = PH_ZERO;
    end else if (im == '0) begin
      q_nxt.byp     = 1'b1;
      q_nxt.byp_val = re[SUM_W-1] ? PH_PI : PH_ZERO;
    end else if (re == '0) begin
      q_nxt.byp     = 1'b1;
      q_nxt.byp_val = im[SUM_W-1] ? PH_NEG_HPI : PH_HALF_PI;
    end
    if (xe[XW-1]) begin
      if (!ye[XW-1]) begin
        q_nxt.x = ye;
        q_nxt.y = -xe;
        q_nxt.z = ZW'(1) <<< (PHASE_BITS - 2);
      end else begin
        q_nxt.x = -ye;
        q_nxt.y = xe;
        q_nxt.z = -(ZW'(1) <<< (PHASE_BITS - 2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

### rtl/core/fmqd_cell.sv
// ----------------------------------------------------------------------------
// fmqd_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module fmqd_cell import fmqd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [SHW-1:0]       shift,
  input  logic signed [ZW-1:0] angle,
  input  cord_t                d,
  output cord_t                q
);

  cord_t                q_r, q_nxt;
  logic signed [XW-1:0] xs, ys;

  assign xs = d.x >>> shift;
  assign ys = d.y >>> shift;

  always_comb begin
    q_nxt = d;
    if (!d.y[XW-1]) begin
      q_nxt.x = d.x + ys;
      q_nxt.y = d.y - xs;
      q_nxt.z = d.z + angle;
    end else begin
      q_nxt.x = d.x - ys;
      q_nxt.y = d.y + xs;
      q_nxt.z = d.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

### rtl/core/fm_quadrature_discriminator_top.sv
// Words pass the product, front, CORDIC cell and output registers in turn.
// Throughput: one word per cycle while out_tready is high; the whole
// pipeline, front product stage and CORDIC cell row, holds while a result waits.
// Reset: synchronous, active low; clears the held sample and all valid flags,
// so the first word after reset yields no result.
// ----------------------------------------------------------------------------
// fm_quadrature_discriminator_top
// FM polar discriminator: angle of the conjugate product by a CORDIC row.
// ----------------------------------------------------------------------------
module fm_quadrature_discriminator_top import fmqd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // i_raw[7:0], q_raw[15:8]
  input  logic             in_tuser,   // restart
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata   // phase_step[15:0]
);

  localparam int SR  = (PHASE_BITS > OUT_W) ? PHASE_BITS - OUT_W : 0;
  localparam int SRH = (SR > 0) ? SR - 1 : 0;
  localparam int SL  = (PHASE_BITS < OUT_W) ? OUT_W - PHASE_BITS : 0;
  localparam int RW  = ZW + OUT_W;

  logic              en, acc;
  cord_t             chain [CORDIC_STAGES+1];
  cord_t             last;
  logic signed [RW-1:0] zw;
  logic [OUT_W-1:0]  ph;

  logic              out_vld_r;
  logic [OUT_W-1:0]  out_data_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  fmqd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .acc     (acc),
    .i_raw   (in_tdata[7:0]),
    .q_raw   (in_tdata[15:8]),
    .restart (in_tuser),
    .q       (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    fmqd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .shift (SHW'(g)),
      .angle (stage_angle(g)),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  assign last = chain[CORDIC_STAGES];

  always_comb begin
    zw = {{OUT_W{last.z[ZW-1]}}, last.z};
    if (SR > 0) begin
      zw = (zw + (RW'(1) <<< SRH)) >>> SR;
    end else if (SL > 0) begin
      zw = zw <<< SL;
    end
    ph = last.byp ? last.byp_val : zw[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= ph;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
